// File: sv/ccmv_pkg.sv
// Package: sizes, constants and state types for the class-conditional mean/variance unit.
package ccmv_pkg;

   localparam int FEATURE_COUNT = 57;
   localparam int MAX_ROWS      = 4096;
   localparam int VALUE_BITS    = 24;

   localparam int SAMPLE_W = 24;
   localparam int FEAT_W   = 6;
   localparam int SUM_W    = 36;
   localparam int SQ_W     = 60;
   localparam int MEAN_W   = 24;
   localparam int VAR_W    = 48;
   localparam int ROWS_W   = 13;
   localparam int SQX_W    = 2 * VALUE_BITS;
   localparam int ENTRIES  = 2 * FEATURE_COUNT;
   localparam int ADDR_W   = $clog2(ENTRIES);

   localparam logic [FEAT_W-1:0] LAST_FEATURE = FEAT_W'(FEATURE_COUNT - 1);
   localparam logic [ROWS_W-1:0] ROWS_LIMIT   = ROWS_W'(MAX_ROWS);

   typedef logic [ADDR_W-1:0] addr_type;

   typedef struct packed {
      logic [SUM_W-1:0] vsum;
      logic [SQ_W-1:0]  qsum;
   } entry_type;

   // Divider request from the drain sequencer.
   typedef struct packed {
      logic                start;
      logic [SQ_W-1:0]     dividend;
      logic [ROWS_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [SQ_W-1:0]     quotient;
   } div_rsp_type;

endpackage

// File: sv/ccmv_divider.sv
// Restoring divider: 60-bit dividend by 13-bit divisor, one quotient bit per cycle.
module ccmv_divider
   import ccmv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int CNT_W = $clog2(SQ_W + 1);

   logic [SQ_W-1:0]   quo_ff, quo_in;
   logic [ROWS_W:0]   rem_ff, rem_in;
   logic [ROWS_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [ROWS_W:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[ROWS_W-1:0], quo_ff[SQ_W-1]};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
         cnt_in  = CNT_W'(SQ_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[SQ_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[SQ_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// File: sv/ccmv_multiplier.sv
// Registered 24x24 multiplier for squares of samples and of means.
module ccmv_multiplier
   import ccmv_pkg::*;
(
   input  logic                clock,
   input  logic [SAMPLE_W-1:0] a,
   output logic [SQX_W-1:0]    product
);

   logic [SQX_W-1:0] product_ff;

   always_ff @(posedge clock) begin
      product_ff <= SQX_W'(a[VALUE_BITS-1:0]) * SQX_W'(a[VALUE_BITS-1:0]);
   end

   assign product = product_ff;

endmodule

// File: sv/class_conditional_mean_variance_unit.sv
// Top level: two-class Gaussian naive Bayes training accumulator and statistics drain.
// Usage:
//  req_ channel: one beat per feature value (sample_value, feature_index,
//  class_label, end_of_set). rsp_ channel: one beat per feature, in feature
//  order, carrying both class means, variances and row counts; last_result
//  marks the final feature.
// Accumulate: each beat goes through a read-modify-write of the statistics
//  memory (read, square/add, write back); req_ready is low until it is done.
// After an end_of_set beat the block drains FEATURE_COUNT results. Each result
//  needs four serial divides by the row count on the shared bit-serial divider.
//  During drain each entry is cleared as it is read.
// Reset: a clearing pass writes zero to all 2*FEATURE_COUNT memory entries,
//  one per cycle; req_ready stays low until it completes.
// Stall: a result waits in the output register while rsp_ready is low; the drain
//  computes the next result, then pauses until the waiting one is taken. No beat is lost or repeated.
module class_conditional_mean_variance_unit
   import ccmv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SAMPLE_W-1:0] req_sample_value,
   input  logic [FEAT_W-1:0]   req_feature_index,
   input  logic                req_class_label,
   input  logic                req_end_of_set,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [FEAT_W-1:0]   rsp_out_feature,
   output logic [MEAN_W-1:0]   rsp_mean_class0,
   output logic [MEAN_W-1:0]   rsp_mean_class1,
   output logic [VAR_W-1:0]    rsp_var_class0,
   output logic [VAR_W-1:0]    rsp_var_class1,
   output logic [ROWS_W-1:0]   rsp_rows_class0,
   output logic [ROWS_W-1:0]   rsp_rows_class1,
   output logic                rsp_last_result
);

   typedef enum logic [3:0] {
      CLEAR, IDLE, ACC_RD, ACC_WR,
      DR_RD0, DR_RD1, DR_DIV, DR_WAIT, DR_SQR, DR_VAR, DR_OUT
   } state_type;

   // Statistics memory
   entry_type mem [ENTRIES];
   entry_type rd_data_ff;
   addr_type  rd_addr, wr_addr;
   logic      wr_en;
   entry_type wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   state_type         state_ff;
   addr_type          addr_ff;
   logic [SAMPLE_W-1:0] x_ff;
   logic              eos_ff, hit_ff;
   logic [ROWS_W-1:0] rows_ff [2];
   logic [FEAT_W-1:0] feat_ff;
   logic [1:0]        step_ff;
   entry_type         ent_ff [2];
   logic [MEAN_W-1:0] mean_ff [2];
   logic [SQ_W-1:0]   ex2_ff [2];
   logic [VAR_W-1:0]  var_ff [2];
   logic              dstart_ff;
   logic [SQ_W-1:0]   dnum_ff;
   logic [ROWS_W-1:0] dden_ff;

   logic              out_valid_ff;
   logic [FEAT_W-1:0] o_feat_ff;
   logic [MEAN_W-1:0] o_m0_ff, o_m1_ff;
   logic [VAR_W-1:0]  o_v0_ff, o_v1_ff;
   logic [ROWS_W-1:0] o_r0_ff, o_r1_ff;
   logic              o_last_ff;

   div_req_type       dreq;
   div_rsp_type       drsp;
   logic [SQX_W-1:0]  prod;
   logic [SAMPLE_W-1:0] mul_a;

   assign dreq.start    = dstart_ff;
   assign dreq.dividend = dnum_ff;
   assign dreq.divisor  = dden_ff;

   ccmv_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));
   ccmv_multiplier u_mul (.clock(clock), .a(mul_a), .product(prod));

   assign mul_a = (state_ff == DR_SQR) ? mean_ff[step_ff[0]] : x_ff;

   // Accumulate write data with saturation
   logic [SUM_W:0] vs_add;
   logic [SQ_W:0]  qs_add;
   logic           active_cls;
   assign vs_add = {1'b0, rd_data_ff.vsum} + (SUM_W+1)'(x_ff[VALUE_BITS-1:0]);
   assign qs_add = {1'b0, rd_data_ff.qsum} + (SQ_W+1)'(prod);

   always_comb begin
      rd_addr = addr_ff;
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = '0;
      case (state_ff)
         CLEAR: wr_en = 1'b1;
         ACC_WR: begin
            wr_en = hit_ff;
            wr_data.vsum = vs_add[SUM_W] ? '1 : vs_add[SUM_W-1:0];
            wr_data.qsum = qs_add[SQ_W] ? '1 : qs_add[SQ_W-1:0];
         end
         DR_RD0: wr_en = 1'b1;
         DR_RD1: wr_en = 1'b1;
         DR_OUT: wr_en = 1'b0;
         default: wr_en = 1'b0;
      endcase
   end

   assign active_cls = step_ff[0];
   logic [SQ_W-1:0] quo;
   assign quo = drsp.quotient;
   logic [SQ_W-1:0] m2;
   assign m2 = SQ_W'(prod);

   always_ff @(posedge clock) begin
      dstart_ff <= 1'b0;
      if (reset) begin
         state_ff     <= CLEAR;
         addr_ff      <= '0;
         rows_ff[0]   <= '0;
         rows_ff[1]   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && rsp_ready && state_ff != DR_OUT) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            CLEAR: begin
               if (addr_ff == addr_type'(ENTRIES - 1)) begin
                  state_ff <= IDLE;
               end
               addr_ff <= addr_ff + 1'b1;
            end
            IDLE: begin
               if (req_valid) begin
                  x_ff    <= req_sample_value;
                  eos_ff  <= req_end_of_set;
                  hit_ff  <= req_feature_index < FEAT_W'(FEATURE_COUNT);
                  addr_ff <= req_class_label
                     ? addr_type'(FEATURE_COUNT) + addr_type'(req_feature_index)
                     : addr_type'(req_feature_index);
                  if (req_feature_index == '0 && rows_ff[req_class_label] < ROWS_LIMIT) begin
                     rows_ff[req_class_label] <= rows_ff[req_class_label] + 1'b1;
                  end
                  state_ff <= ACC_RD;
               end
            end
            ACC_RD: state_ff <= ACC_WR;
            ACC_WR: begin
               if (eos_ff) begin
                  feat_ff  <= '0;
                  addr_ff  <= '0;
                  state_ff <= DR_RD0;
               end else begin
                  state_ff <= IDLE;
               end
            end
            DR_RD0: begin
               addr_ff  <= addr_type'(FEATURE_COUNT) + addr_type'(feat_ff);
               state_ff <= DR_RD1;
            end
            DR_RD1: begin
               ent_ff[0] <= rd_data_ff;
               state_ff  <= DR_DIV;
               step_ff   <= 2'd0;
            end
            DR_DIV: begin
               if (step_ff == 2'd0) begin
                  ent_ff[1] <= rd_data_ff;
               end
               dnum_ff   <= step_ff[1] ? ent_ff[step_ff[0]].qsum
                                       : SQ_W'(ent_ff[step_ff[0]].vsum);
               dden_ff   <= rows_ff[step_ff[0]];
               dstart_ff <= 1'b1;
               state_ff  <= DR_WAIT;
            end
            DR_WAIT: begin
               if (drsp.done) begin
                  if (!step_ff[1]) begin
                     mean_ff[active_cls] <= (rows_ff[active_cls] == '0) ? '0
                        : (|quo[SQ_W-1:MEAN_W]) ? '1 : quo[MEAN_W-1:0];
                     step_ff  <= step_ff + 1'b1;
                     state_ff <= DR_DIV;
                  end else begin
                     ex2_ff[active_cls] <= quo;
                     state_ff <= DR_SQR;
                  end
               end
            end
            DR_SQR: state_ff <= DR_VAR;
            DR_VAR: begin
               var_ff[active_cls] <= (rows_ff[active_cls] == '0 || ex2_ff[active_cls] <= m2)
                  ? '0 : (|((ex2_ff[active_cls] - m2) >> VAR_W)) ? '1
                  : VAR_W'(ex2_ff[active_cls] - m2);
               if (step_ff == 2'd3) begin
                  state_ff <= DR_OUT;
               end else begin
                  step_ff  <= step_ff + 1'b1;
                  state_ff <= DR_DIV;
               end
            end
            DR_OUT: begin
               if (!out_valid_ff || rsp_ready) begin
                  out_valid_ff <= 1'b1;
                  o_feat_ff <= feat_ff;
                  o_m0_ff   <= mean_ff[0];
                  o_m1_ff   <= mean_ff[1];
                  o_v0_ff   <= var_ff[0];
                  o_v1_ff   <= var_ff[1];
                  o_r0_ff   <= rows_ff[0];
                  o_r1_ff   <= rows_ff[1];
                  o_last_ff <= feat_ff == LAST_FEATURE;
                  if (feat_ff == LAST_FEATURE) begin
                     rows_ff[0] <= '0;
                     rows_ff[1] <= '0;
                     state_ff   <= IDLE;
                  end else begin
                     feat_ff  <= feat_ff + 1'b1;
                     addr_ff  <= addr_type'(feat_ff + 1'b1);
                     state_ff <= DR_RD0;
                  end
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign req_ready       = (state_ff == IDLE);
   assign rsp_valid       = out_valid_ff;
   assign rsp_out_feature = o_feat_ff;
   assign rsp_mean_class0 = o_m0_ff;
   assign rsp_mean_class1 = o_m1_ff;
   assign rsp_var_class0  = o_v0_ff;
   assign rsp_var_class1  = o_v1_ff;
   assign rsp_rows_class0 = o_r0_ff;
   assign rsp_rows_class1 = o_r1_ff;
   assign rsp_last_result = o_last_ff;

   a_no_accept_in_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff != IDLE) |-> !req_ready)
      else $error("accept outside idle");
   a_rows_bound: assert property (@(posedge clock) disable iff (reset)
      (rows_ff[0] <= ROWS_LIMIT) && (rows_ff[1] <= ROWS_LIMIT))
      else $error("row count beyond limit");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> (out_valid_ff && $stable(o_feat_ff)))
      else $error("result dropped under stall");

endmodule

// File: verif/class_conditional_mean_variance_unit_checker.sv
// Checker: watches both channels, predicts the per-feature statistics and compares each result beat.
`timescale 1ns / 100ps
module class_conditional_mean_variance_unit_checker
   import ccmv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [SAMPLE_W-1:0] req_sample_value,
   input  logic [FEAT_W-1:0]   req_feature_index,
   input  logic                req_class_label,
   input  logic                req_end_of_set,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [FEAT_W-1:0]   rsp_out_feature,
   input  logic [MEAN_W-1:0]   rsp_mean_class0,
   input  logic [MEAN_W-1:0]   rsp_mean_class1,
   input  logic [VAR_W-1:0]    rsp_var_class0,
   input  logic [VAR_W-1:0]    rsp_var_class1,
   input  logic [ROWS_W-1:0]   rsp_rows_class0,
   input  logic [ROWS_W-1:0]   rsp_rows_class1,
   input  logic                rsp_last_result,
   output int                  fail_count,
   output int                  pending_stats,
   output int                  stats_seen,
   output int                  sets_closed
);

   typedef struct packed {
      logic [FEAT_W-1:0] feat;
      logic [MEAN_W-1:0] mean0;
      logic [MEAN_W-1:0] mean1;
      logic [VAR_W-1:0]  var0;
      logic [VAR_W-1:0]  var1;
      logic [ROWS_W-1:0] rows0;
      logic [ROWS_W-1:0] rows1;
      logic              last;
   } feature_stats_type;

   localparam logic [63:0] SUM_LIMIT  = (64'd1 << SUM_W) - 1;
   localparam logic [63:0] SQ_LIMIT   = (64'd1 << SQ_W) - 1;
   localparam logic [63:0] MEAN_LIMIT = (64'd1 << MEAN_W) - 1;
   localparam logic [63:0] VAR_LIMIT  = (64'd1 << VAR_W) - 1;

   logic [63:0]       acc_sum [ENTRIES];
   logic [63:0]       acc_sq  [ENTRIES];
   logic [ROWS_W-1:0] row_cnt [2];
   feature_stats_type expected_stats [$];

   assign pending_stats = expected_stats.size();

   function automatic logic [63:0] add_clamped(logic [63:0] acc, logic [63:0] inc,
                                               logic [63:0] lim);
      if (acc >= lim || inc > lim - acc) return lim;
      return acc + inc;
   endfunction

   task automatic class_moments(input int cls, input int f, output logic [MEAN_W-1:0] mean,
                                output logic [VAR_W-1:0] vr);
      logic [63:0] rows, m, ex2, m2;
      rows = 64'(row_cnt[cls]);
      if (rows == 0) begin
         mean = '0;
         vr   = '0;
      end else begin
         m = acc_sum[cls*FEATURE_COUNT+f] / rows;
         if (m > MEAN_LIMIT) m = MEAN_LIMIT;
         ex2 = acc_sq[cls*FEATURE_COUNT+f] / rows;
         m2 = m * m;
         if (ex2 <= m2) vr = '0;
         else vr = (ex2 - m2 > VAR_LIMIT) ? VAR_LIMIT[VAR_W-1:0] : VAR_W'(ex2 - m2);
         mean = MEAN_W'(m);
      end
   endtask

   task automatic clear_model();
      for (int i = 0; i < ENTRIES; i++) begin
         acc_sum[i] = '0;
         acc_sq[i]  = '0;
      end
      row_cnt[0] = '0;
      row_cnt[1] = '0;
   endtask

   task automatic accumulate_beat();
      logic [63:0]       x;
      int                at;
      feature_stats_type s;
      x = 64'(req_sample_value[VALUE_BITS-1:0]);
      if (req_feature_index < FEATURE_COUNT) begin
         at = int'(req_class_label) * FEATURE_COUNT + int'(req_feature_index);
         acc_sum[at] = add_clamped(acc_sum[at], x, SUM_LIMIT);
         acc_sq[at]  = add_clamped(acc_sq[at], x * x, SQ_LIMIT);
         if (req_feature_index == 0 && row_cnt[req_class_label] < ROWS_LIMIT)
            row_cnt[req_class_label]++;
      end
      if (req_end_of_set) begin
         for (int f = 0; f < FEATURE_COUNT; f++) begin
            s.feat = FEAT_W'(f);
            class_moments(0, f, s.mean0, s.var0);
            class_moments(1, f, s.mean1, s.var1);
            s.rows0 = row_cnt[0];
            s.rows1 = row_cnt[1];
            s.last  = (s.feat == LAST_FEATURE);
            expected_stats.push_back(s);
         end
         clear_model();
         sets_closed++;
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   task automatic compare_beat();
      feature_stats_type e;
      if (expected_stats.size() == 0) begin
         $error("result beat for feature %0d with nothing expected", rsp_out_feature);
         fail_count++;
         return;
      end
      e = expected_stats.pop_front();
      stats_seen++;
      check_field("out_feature", 64'(e.feat), 64'(rsp_out_feature));
      check_field("mean_class0", 64'(e.mean0), 64'(rsp_mean_class0));
      check_field("mean_class1", 64'(e.mean1), 64'(rsp_mean_class1));
      check_field("var_class0", 64'(e.var0), 64'(rsp_var_class0));
      check_field("var_class1", 64'(e.var1), 64'(rsp_var_class1));
      check_field("rows_class0", 64'(e.rows0), 64'(rsp_rows_class0));
      check_field("rows_class1", 64'(e.rows1), 64'(rsp_rows_class1));
      check_field("last_result", 64'(e.last), 64'(rsp_last_result));
   endtask

   initial begin
      fail_count  = 0;
      stats_seen  = 0;
      sets_closed = 0;
      clear_model();
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) accumulate_beat();
         if (rsp_valid && rsp_ready) compare_beat();
      end
   end

endmodule

// File: verif/class_conditional_mean_variance_unit_tb.sv
// Testbench top: clock, reset, training-set stimulus, receiver stalls, watchdog and verdict.
`timescale 1ns / 100ps
module class_conditional_mean_variance_unit_tb;
   import ccmv_pkg::*;

   localparam int IDLE_LIMIT = 40000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [SAMPLE_W-1:0] req_sample_value = '0;
   logic [FEAT_W-1:0]   req_feature_index = '0;
   logic                req_class_label = 1'b0;
   logic                req_end_of_set = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [FEAT_W-1:0]   rsp_out_feature;
   logic [MEAN_W-1:0]   rsp_mean_class0;
   logic [MEAN_W-1:0]   rsp_mean_class1;
   logic [VAR_W-1:0]    rsp_var_class0;
   logic [VAR_W-1:0]    rsp_var_class1;
   logic [ROWS_W-1:0]   rsp_rows_class0;
   logic [ROWS_W-1:0]   rsp_rows_class1;
   logic                rsp_last_result;

   int fail_count, pending_stats, stats_seen, sets_closed;
   int send_idle_pct = 12;
   int recv_idle_pct = 59;
   int quiet_cycles  = 0;
   int beats_sent    = 0;

   always #5 clock = ~clock;

   class_conditional_mean_variance_unit DUT (.*);
   class_conditional_mean_variance_unit_checker checker_i (.*);

   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("class_conditional_mean_variance_unit_tb NOT OK");
         $finish;
      end
   end

   task automatic send_value(input logic [SAMPLE_W-1:0] v, input logic [FEAT_W-1:0] f,
                             input logic c, input logic eos);
      logic ok;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid         = 1'b1;
      req_sample_value  = v;
      req_feature_index = f;
      req_class_label   = c;
      req_end_of_set    = eos;
      forever begin
         #1 ok = req_ready;
         @(posedge clock);
         if (ok) break;
         @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b0;
      beats_sent++;
   endtask

   function automatic logic [SAMPLE_W-1:0] rand_value();
      case ($urandom_range(3))
         0: return SAMPLE_W'($urandom_range(255));
         1: return '1;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // random rows with feature-0 first, some noise beats, end of set at the end
   task automatic random_set(input int n);
      int sent, width, c;
      sent = 0;
      while (sent < n) begin
         if ($urandom_range(9) == 0) begin
            send_value(rand_value(), FEAT_W'($urandom_range(FEATURE_COUNT, 63)),
                       1'($urandom), 1'b0);
            sent++;
         end else begin
            c = $urandom_range(1);
            width = $urandom_range(1, 6);
            for (int k = 0; k < width; k++)
               send_value(rand_value(), (k == 0) ? '0 :
                          FEAT_W'($urandom_range(1, FEATURE_COUNT - 1)), 1'(c), 1'b0);
            if ($urandom_range(9) == 0)
               send_value(rand_value(), LAST_FEATURE, 1'(c), 1'b0);
            sent += width;
         end
      end
      send_value(rand_value(), FEAT_W'($urandom_range(FEATURE_COUNT - 1)),
                 1'($urandom), 1'b1);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // class 1 without rows; extremes; out-of-range features; end on an ignored index
      send_value('0, '0, 1'b0, 1'b0);
      send_value('1, LAST_FEATURE, 1'b0, 1'b0);
      send_value('1, '0, 1'b0, 1'b0);
      send_value(24'h000100, 6'd1, 1'b0, 1'b0);
      send_value(24'h555555, 6'd1, 1'b0, 1'b0);
      send_value('1, 6'd2, 1'b1, 1'b0);
      send_value('1, 6'd57, 1'b0, 1'b0);
      send_value('1, 6'd63, 1'b1, 1'b0);
      send_value(24'hAAAAAA, 6'd63, 1'b0, 1'b1);
      // class 0 empty; end on a feature-0 beat
      send_value(24'h000003, '0, 1'b1, 1'b0);
      send_value(24'h000005, 6'd1, 1'b1, 1'b0);
      send_value(24'h000002, '0, 1'b1, 1'b0);
      send_value(24'h000004, 6'd1, 1'b1, 1'b0);
      send_value(24'h000007, '0, 1'b1, 1'b1);
      // nothing accumulated at all
      send_value(24'h123456, 6'd60, 1'b1, 1'b1);

      for (int m = 0; m < 3; m++) begin
         if (m == 1) begin
            send_idle_pct = 59;
            recv_idle_pct = 12;
         end else if (m == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int s = 0; s < 3; s++) random_set($urandom_range(20, 34));
      end

      // all-ones samples: class 0 rows, then a class 1 beat on the last feature ends the set
      for (int i = 0; i < 8; i++) send_value('1, '0, 1'b0, 1'b0);
      send_value('1, LAST_FEATURE, 1'b1, 1'b1);

      wait (pending_stats == 0);
      repeat (400) @(posedge clock);
      $display("Sent %0d sample beats in %0d training sets; checked %0d feature results.",
               beats_sent, sets_closed, stats_seen);
      $display("Covered empty classes, ignored indexes, three stall mixes and all-ones data.");
      if (fail_count == 0 && pending_stats == 0)
         $display("class_conditional_mean_variance_unit_tb OK");
      else
         $display("class_conditional_mean_variance_unit_tb NOT OK");
      $finish;
   end

endmodule
